@@ rtl/mtp_pkg.sv @@
// shared constants, types and datapath functions of the mersenne twister core
package mtp_pkg;

  localparam int unsigned StateWords   = 624;
  localparam int unsigned MiddleOffset = 397;
  localparam int unsigned WordW        = 32;
  localparam int unsigned IdxW         = $clog2(StateWords);

  localparam logic [WordW-1:0] TwistMatrix = 32'h9908_B0DF;
  localparam logic [WordW-1:0] TemperB     = 32'h9D2C_5680;
  localparam logic [WordW-1:0] TemperC     = 32'hEFC6_0000;
  localparam logic [WordW-1:0] SeedMult    = 32'd69069;
  localparam logic [WordW-1:0] DefaultSeed = 32'd4357;
  localparam logic [WordW-1:0] UpperMask   = 32'h8000_0000;
  localparam logic [WordW-1:0] LowerMask   = 32'h7FFF_FFFF;
  localparam logic [WordW-1:0] OddBit      = 32'h0000_0001;

  localparam logic ModeSeed = 1'b0;
  localparam logic ModeDraw = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StSeed,
    StTwPre,
    StTwRun,
    StTwDrain,
    StRead,
    StOut
  } state_e;

  // memory and datapath controls from the sequencer
  typedef struct packed {
    logic             seed_we;
    logic             twist_we;
    logic [IdxW-1:0]  wr_idx;
    logic [WordW-1:0] seed_word;
    logic             rd_a_en;
    logic [IdxW-1:0]  rd_a_idx;
    logic             rd_b_en;
    logic [IdxW-1:0]  rd_b_idx;
    logic             cur_load;
    logic             out_load;
  } mem_ctrl_t;

  function automatic logic [WordW-1:0] twist_word(input logic [WordW-1:0] cur,
                                                  input logic [WordW-1:0] nxt,
                                                  input logic [WordW-1:0] far);
    logic [WordW-1:0] mixed;
    mixed = (cur & UpperMask) | (nxt & LowerMask);
    return far ^ (mixed >> 1) ^ ((nxt & OddBit) != '0 ? TwistMatrix : '0);
  endfunction

  function automatic logic [WordW-1:0] temper(input logic [WordW-1:0] w);
    logic [WordW-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    return y ^ (y >> 18);
  endfunction

endpackage

@@ rtl/mtp_ram.sv @@
// generic ram: one write port, two read ports with registered read data
module mtp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic                     re_b_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ rtl/mtp_ctrl.sv @@
// sequencer: seeding sweep, twist sweep, draw read and read position
module mtp_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     mode_i,
  input  logic [mtp_pkg::WordW-1:0] seed_value_i,
  input  logic                     out_busy_i,
  output logic                     in_stall_o,
  output mtp_pkg::mem_ctrl_t       ctrl_o
);

  localparam int unsigned IdxW = mtp_pkg::IdxW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(mtp_pkg::StateWords - 1);
  localparam logic [IdxW:0]   Words   = (IdxW+1)'(mtp_pkg::StateWords);
  localparam logic [IdxW:0]   Offset  = (IdxW+1)'(mtp_pkg::MiddleOffset);

  mtp_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]           cnt_q, cnt_d;
  logic [IdxW-1:0]           wr_idx_q, wr_idx_d;
  logic                      wr_pend_q, wr_pend_d;
  logic [IdxW-1:0]           rd_idx_q, rd_idx_d;
  logic                      seeded_q, seeded_d;
  logic                      draw_pend_q, draw_pend_d;
  logic [mtp_pkg::WordW-1:0] x_q, x_d;
  logic [IdxW:0]             far_sum;
  logic [IdxW-1:0]           far_idx;
  logic [IdxW-1:0]           nxt_idx;
  logic                      accept;

  assign in_stall_o = (state_q != mtp_pkg::StIdle);
  assign accept     = in_valid_i && !in_stall_o;

  // offset partner of the word being twisted, modulo the state size
  assign far_sum = {1'b0, cnt_q} + Offset;
  assign far_idx = (far_sum >= Words) ? IdxW'(far_sum - Words) : far_sum[IdxW-1:0];
  assign nxt_idx = (cnt_q == LastIdx) ? '0 : cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtp_pkg::StIdle;
      cnt_q       <= '0;
      wr_pend_q   <= 1'b0;
      rd_idx_q    <= IdxW'(mtp_pkg::StateWords);
      seeded_q    <= 1'b0;
      draw_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wr_pend_q   <= wr_pend_d;
      rd_idx_q    <= rd_idx_d;
      seeded_q    <= seeded_d;
      draw_pend_q <= draw_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    wr_idx_q <= wr_idx_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    wr_idx_d    = cnt_q;
    wr_pend_d   = 1'b0;
    rd_idx_d    = rd_idx_q;
    seeded_d    = seeded_q;
    draw_pend_d = draw_pend_q;
    x_d         = x_q;

    ctrl_o           = '0;
    ctrl_o.wr_idx    = wr_pend_q ? wr_idx_q : cnt_q;
    ctrl_o.seed_word = x_q;
    ctrl_o.twist_we  = wr_pend_q;

    unique case (state_q)
      mtp_pkg::StIdle: begin
        if (accept) begin
          cnt_d = '0;
          if (mode_i == mtp_pkg::ModeSeed) begin
            x_d         = seed_value_i | mtp_pkg::OddBit;
            draw_pend_d = 1'b0;
            state_d     = mtp_pkg::StSeed;
          end else if (!seeded_q) begin
            x_d         = mtp_pkg::DefaultSeed | mtp_pkg::OddBit;
            draw_pend_d = 1'b1;
            state_d     = mtp_pkg::StSeed;
          end else if ({1'b0, rd_idx_q} >= Words) begin
            state_d = mtp_pkg::StTwPre;
          end else begin
            state_d = mtp_pkg::StRead;
          end
        end
      end
      mtp_pkg::StSeed: begin
        ctrl_o.seed_we = 1'b1;
        x_d            = x_q * mtp_pkg::SeedMult;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          cnt_d    = '0;
          seeded_d = 1'b1;
          rd_idx_d = IdxW'(mtp_pkg::StateWords);
          state_d  = draw_pend_q ? mtp_pkg::StTwPre : mtp_pkg::StIdle;
        end
      end
      mtp_pkg::StTwPre: begin
        // fetch word zero so the sweep starts with its current word in hand
        ctrl_o.rd_a_en  = 1'b1;
        ctrl_o.rd_a_idx = '0;
        state_d         = mtp_pkg::StTwRun;
      end
      mtp_pkg::StTwRun: begin
        ctrl_o.rd_a_en  = 1'b1;
        ctrl_o.rd_a_idx = nxt_idx;
        ctrl_o.rd_b_en  = 1'b1;
        ctrl_o.rd_b_idx = far_idx;
        ctrl_o.cur_load = 1'b1;
        wr_pend_d       = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = mtp_pkg::StTwDrain;
        end
      end
      mtp_pkg::StTwDrain: begin
        // last twisted word is written this cycle
        rd_idx_d    = '0;
        draw_pend_d = 1'b0;
        state_d     = mtp_pkg::StRead;
      end
      mtp_pkg::StRead: begin
        ctrl_o.rd_a_en  = 1'b1;
        ctrl_o.rd_a_idx = rd_idx_q;
        state_d         = mtp_pkg::StOut;
      end
      mtp_pkg::StOut: begin
        if (!out_busy_i) begin
          ctrl_o.out_load = 1'b1;
          rd_idx_d        = rd_idx_q + 1'b1;
          state_d         = mtp_pkg::StIdle;
        end
      end
      default: begin
        state_d = mtp_pkg::StIdle;
      end
    endcase
  end

endmodule

@@ rtl/mersenne_twister_prng_core.sv @@
// top level of the mt19937 generator: state memory, twist and tempering datapath
//
//  beat      direction  signals                         meaning
//  in        sink       in_valid_i in_stall_o           mode_i, seed_value_i
//  out       source     out_valid_o out_stall_i         random_word_o
//
// a seed beat stalls the input while it refills the state memory, one word a cycle
// a draw stalls the input through the read and output states while words remain, and its result
// is held in the output register; when the state is used up the twist sweep runs first
// a draw before any seed first runs the default seeding
// the state memory has no reset; read position and seeded flag reset at once
// a stalled result waits in the output register while the next beat is taken
module mersenne_twister_prng_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [31:0] seed_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] random_word_o
);

  localparam int unsigned WordW = mtp_pkg::WordW;

  mtp_pkg::mem_ctrl_t ctrl;
  logic [WordW-1:0]   rdata_a;
  logic [WordW-1:0]   rdata_b;
  logic [WordW-1:0]   wdata;
  logic [WordW-1:0]   cur_q;
  logic [WordW-1:0]   word_q;
  logic               out_valid_q, out_valid_d;
  logic               out_busy;

  assign out_busy = out_valid_q && out_stall_i;

  mtp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .mode_i       (mode_i),
    .seed_value_i (seed_value_i),
    .out_busy_i   (out_busy),
    .in_stall_o   (in_stall_o),
    .ctrl_o       (ctrl)
  );

  // read port a carries the next word during the twist, so it is also the
  // current word of the following step
  assign wdata = ctrl.seed_we ? ctrl.seed_word
                              : mtp_pkg::twist_word(cur_q, rdata_a, rdata_b);

  mtp_ram #(
    .Width (WordW),
    .Depth (mtp_pkg::StateWords)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ctrl.seed_we || ctrl.twist_we),
    .waddr_i   (ctrl.wr_idx),
    .wdata_i   (wdata),
    .re_a_i    (ctrl.rd_a_en),
    .raddr_a_i (ctrl.rd_a_idx),
    .rdata_a_o (rdata_a),
    .re_b_i    (ctrl.rd_b_en),
    .raddr_b_i (ctrl.rd_b_idx),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.cur_load) begin
      cur_q <= rdata_a;
    end
    if (ctrl.out_load) begin
      word_q <= mtp_pkg::temper(rdata_a);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = word_q;

endmodule

@@ rtl/mtp_checker.sv @@
// port-level checks of the mt19937 core, bound to the top level
module mtp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        mode_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] random_word_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(random_word_o))
    else $error("stalled result beat changed");

  // one item at a time: input is stalled right after a beat is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again while busy");

  // a seed beat gives no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i == 1'b0 && !out_valid_o |=> !out_valid_o)
    else $error("result appeared after a seed beat");

  // no result shown once reset has been seen at an edge
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind mersenne_twister_prng_core mtp_checker u_mtp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .mode_i        (mode_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .random_word_o (random_word_o)
);

@@ test/tb_top.sv @@
// self-checking testbench for the mt19937 generator core: seeding, draws and twist wrap
`timescale 1ns / 1ps

module tb_top;

  localparam int ClkPeriod     = 4;
  localparam int ResetCycles   = 12;
  localparam int IdlePercent   = 23;
  localparam int HoldCycles    = 300;
  localparam int DrainCycles   = 1500;
  localparam int RandomItems   = 1900;
  localparam int TimeoutCycles = 1_000_000;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic        mode_i       = mtp_pkg::ModeSeed;
  logic [31:0] seed_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [31:0] random_word_o;

  // generator state as predicted from the accepted beats
  logic [mtp_pkg::WordW-1:0] twist_state [mtp_pkg::StateWords];
  int unsigned               word_pos    = mtp_pkg::StateWords;
  bit                        is_seeded   = 1'b0;
  logic [31:0]               expected_words [$];

  int errors   = 0;
  bit gaps_on  = 1'b1;
  bit hold_req = 1'b0;

  mersenne_twister_prng_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .seed_value_i  (seed_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .random_word_o (random_word_o)
  );

  always begin
    clk_i = 1'b0;
    #(ClkPeriod / 2);
    clk_i = 1'b1;
    #(ClkPeriod / 2);
  end

  function automatic void fill_state(input logic [31:0] seed);
    logic [31:0] x;
    x = seed | mtp_pkg::OddBit;
    for (int i = 0; i < mtp_pkg::StateWords; i++) begin
      twist_state[i] = x;
      x = x * mtp_pkg::SeedMult;
    end
    word_pos  = mtp_pkg::StateWords;
    is_seeded = 1'b1;
  endfunction

  function automatic void predict_beat(input logic mode, input logic [31:0] seed);
    logic [31:0] cur, nxt, far, mixed, y;
    if (mode == mtp_pkg::ModeSeed) begin
      fill_state(seed);
      return;
    end
    if (!is_seeded) fill_state(mtp_pkg::DefaultSeed);
    if (word_pos >= mtp_pkg::StateWords) begin
      // regenerate in place, later words see the already twisted ones
      for (int i = 0; i < mtp_pkg::StateWords; i++) begin
        cur   = twist_state[i];
        nxt   = twist_state[(i + 1) % mtp_pkg::StateWords];
        far   = twist_state[(i + mtp_pkg::MiddleOffset) % mtp_pkg::StateWords];
        mixed = (cur & mtp_pkg::UpperMask) | (nxt & mtp_pkg::LowerMask);
        twist_state[i] = far ^ (mixed >> 1) ^ (nxt[0] ? mtp_pkg::TwistMatrix : 32'h0);
      end
      word_pos = 0;
    end
    y = twist_state[word_pos];
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & mtp_pkg::TemperB);
    y = y ^ ((y << 15) & mtp_pkg::TemperC);
    y = y ^ (y >> 18);
    expected_words.push_back(y);
    word_pos++;
  endfunction

  // offer one beat and hold it until taken; valid stays high for a following beat
  task automatic send_beat(input logic mode, input logic [31:0] seed);
    while (gaps_on && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    seed_value_i <= seed;
    do @(posedge clk_i); while (in_stall_o);
    predict_beat(mode, seed);
  endtask

  task automatic draw_words(input int n);
    repeat (n) send_beat(mtp_pkg::ModeDraw, $urandom);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_unseeded_draw();
    draw_words(3);
  endtask

  task automatic test_seed_extremes();
    send_beat(mtp_pkg::ModeSeed, 32'h0000_0000);
    draw_words(2);
    send_beat(mtp_pkg::ModeSeed, 32'hFFFF_FFFF);
    draw_words(2);
  endtask

  task automatic test_even_odd_seed();
    send_beat(mtp_pkg::ModeSeed, 32'h1234_5678);
    draw_words(2);
    send_beat(mtp_pkg::ModeSeed, 32'h1234_5679);
    draw_words(2);
    // back-to-back seeds, only the second one counts
    send_beat(mtp_pkg::ModeSeed, 32'hA5A5_5A5A);
    send_beat(mtp_pkg::ModeSeed, 32'h5A5A_A5A5);
    draw_words(1);
  endtask

  task automatic test_output_hold();
    hold_req <= 1'b1;
    draw_words(40);
  endtask

  task automatic test_sender_pause();
    wait_results_drained();
    draw_words(5);
  endtask

  task automatic test_random_runs();
    int sent;
    int run;
    sent = 0;
    while (sent < RandomItems) begin
      gaps_on = !(sent > 800 && sent < 1100);
      if ($urandom_range(4) != 0) begin
        send_beat(mtp_pkg::ModeSeed, $urandom);
        sent++;
      end
      // mostly short runs, now and then one long enough to wrap the state
      run = ($urandom_range(3) == 0) ? $urandom_range(650, 1300) : $urandom_range(1, 60);
      if (sent + run > RandomItems) run = RandomItems - sent;
      draw_words(run);
      sent += run;
    end
    gaps_on = 1'b1;
  endtask

  initial begin : rx_side
    int unsigned hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req <= 1'b0;
        hold_cnt = HoldCycles;
      end
      if (hold_cnt > 0) begin
        out_stall_i <= 1'b1;
        hold_cnt--;
      end else begin
        out_stall_i <= gaps_on && ($urandom_range(99) < IdlePercent);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $error("random_word: no expected beat waiting, actual %08h", random_word_o);
        errors++;
      end else begin
        if (random_word_o !== expected_words[0]) begin
          $error("random_word mismatch: expected %08h, actual %08h",
                 expected_words[0], random_word_o);
          errors++;
        end
        void'(expected_words.pop_front());
      end
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_unseeded_draw();
    test_seed_extremes();
    test_even_odd_seed();
    test_output_hold();
    test_sender_pause();
    test_random_runs();
    wait_results_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_words.size() != 0) begin
      $error("random_word: %0d expected beats never arrived", expected_words.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
